>>> design/prefix_trie_max_weight_macros.svh
// Assertion macros for the prefix trie lookup block.
`ifndef PREFIX_TRIE_MAX_WEIGHT_MACROS_SVH
`define PREFIX_TRIE_MAX_WEIGHT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define PTMW_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("prefix trie check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define PTMW_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("prefix trie check failed");

`endif

>>> design/ptmw_pkg.sv
// Package: sizes, status codes and controller states of the prefix trie lookup.
package ptmw_pkg;

  localparam int NODE_COUNT    = 4096;
  localparam int ALPHABET_SIZE = 26;
  localparam int WEIGHT_BITS   = 20;
  localparam int LETTER_BITS   = 5;
  localparam int NODE_BITS     = $clog2(NODE_COUNT);
  localparam int USED_BITS     = $clog2(NODE_COUNT + 1);
  localparam int SLOT_COUNT    = NODE_COUNT * ALPHABET_SIZE;
  localparam int SLOT_BITS     = $clog2(SLOT_COUNT);

  localparam logic [1:0] STAT_DONE      = 2'd0;
  localparam logic [1:0] STAT_NOT_FOUND = 2'd1;
  localparam logic [1:0] STAT_TRUNCATED = 2'd2;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_LINK,
    S_WEIGHT
  } state_t;

endpackage

>>> design/prefix_trie_max_weight.sv
// Top level: letter-serial prefix trie with insert and max-weight query.
// An item ends in its accepting step if the walk has failed, else it goes on to a step that reads one child link,
// and to a further step when it also reads an existing child's weight (insert, or query last letter).
// The link memory read and the weight memory read-modify-write set these steps.
// done rises in the cycle after the item's last step; busy is high in the steps after the accepting one.
// After rst a clearing pass zeroes all 106496 link memory slots with busy high.
`include "prefix_trie_max_weight_macros.svh"

module prefix_trie_max_weight
  import ptmw_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic                          operation,
  input  logic [LETTER_BITS-1:0]        letter,
  input  logic [WEIGHT_BITS-1:0]        weight,
  input  logic                          first_letter,
  input  logic                          last_letter,
  output logic                          done,
  output logic signed [WEIGHT_BITS:0]   best_weight,
  output logic [1:0]                    status
);

  state_t state, state_next;

  logic [NODE_BITS-1:0]   link_mem [SLOT_COUNT];
  logic [WEIGHT_BITS-1:0] weight_mem [NODE_COUNT];

  logic [SLOT_BITS-1:0]   clr_addr;
  logic [NODE_BITS-1:0]   cursor, cursor_next;
  logic                   failed, failed_next;
  logic [USED_BITS-1:0]   nodes_used, nodes_used_next;
  logic                   op_q, last_q;
  logic [WEIGHT_BITS-1:0] wt_q;
  logic [SLOT_BITS-1:0]   slot_q;

  logic [NODE_BITS-1:0]   link_rd;
  logic [WEIGHT_BITS-1:0] weight_rd;

  logic                   accept, bad_letter, failed_eff, walk_ok, pool_full;
  logic [NODE_BITS-1:0]   cursor_eff;
  logic [SLOT_BITS-1:0]   slot_addr;

  logic                   link_we;
  logic [SLOT_BITS-1:0]   link_wa;
  logic [NODE_BITS-1:0]   link_wd;
  logic                   wt_we;
  logic [NODE_BITS-1:0]   wt_wa;
  logic [WEIGHT_BITS-1:0] wt_wd;
  logic [NODE_BITS-1:0]   wt_ra;
  logic                   res_fire;
  logic [WEIGHT_BITS:0]   res_best;
  logic [1:0]             res_status;

  assign busy       = (state != S_IDLE);
  assign accept     = start && !busy;
  assign cursor_eff = first_letter ? '0 : cursor;
  assign failed_eff = first_letter ? 1'b0 : failed;
  assign bad_letter = (letter >= LETTER_BITS'(ALPHABET_SIZE));
  assign walk_ok    = !failed_eff && !bad_letter;
  assign pool_full  = (nodes_used == USED_BITS'(NODE_COUNT));
  assign slot_addr  = SLOT_BITS'(cursor_eff) * SLOT_BITS'(ALPHABET_SIZE)
                      + SLOT_BITS'(letter);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (clr_addr == SLOT_BITS'(SLOT_COUNT - 1)) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (start && walk_ok) state_next = S_LINK;
      end
      S_LINK: begin
        if (link_rd != '0 && (!op_q || last_q)) state_next = S_WEIGHT;
        else state_next = S_IDLE;
      end
      S_WEIGHT: state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // datapath control
  always_comb begin
    cursor_next     = cursor;
    failed_next     = failed;
    nodes_used_next = nodes_used;
    link_we         = 1'b0;
    link_wa         = slot_q;
    link_wd         = '0;
    wt_we           = 1'b0;
    wt_wa           = cursor;
    wt_wd           = wt_q;
    wt_ra           = link_rd;
    res_fire        = 1'b0;
    res_best        = '0;
    res_status      = STAT_DONE;
    case (state)
      S_CLEAR: begin
        link_we = 1'b1;
        link_wa = clr_addr;
      end
      S_IDLE: begin
        if (start) begin
          cursor_next = cursor_eff;
          failed_next = !walk_ok;
          if (!walk_ok && last_letter) begin
            res_fire   = 1'b1;
            res_best   = operation ? '1 : '0;
            res_status = operation ? STAT_NOT_FOUND : STAT_TRUNCATED;
          end
        end
      end
      S_LINK: begin
        if (link_rd != '0) begin
          cursor_next = link_rd;
        end else if (op_q) begin
          failed_next = 1'b1;
          res_fire    = last_q;
          res_best    = '1;
          res_status  = STAT_NOT_FOUND;
        end else if (pool_full) begin
          failed_next = 1'b1;
          res_fire    = last_q;
          res_status  = STAT_TRUNCATED;
        end else begin
          link_we         = 1'b1;
          link_wd         = nodes_used[NODE_BITS-1:0];
          wt_we           = 1'b1;
          wt_wa           = nodes_used[NODE_BITS-1:0];
          cursor_next     = nodes_used[NODE_BITS-1:0];
          nodes_used_next = nodes_used + 1'b1;
          res_fire        = last_q;
        end
      end
      S_WEIGHT: begin
        if (!op_q) begin
          wt_we    = (weight_rd < wt_q);
          res_fire = last_q;
        end else begin
          res_fire = 1'b1;
          res_best = {1'b0, weight_rd};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_addr   <= '0;
      cursor     <= '0;
      failed     <= 1'b0;
      nodes_used <= USED_BITS'(1);
      done       <= 1'b0;
    end else begin
      state      <= state_next;
      cursor     <= cursor_next;
      failed     <= failed_next;
      nodes_used <= nodes_used_next;
      done       <= res_fire;
      if (state == S_CLEAR) clr_addr <= clr_addr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_q   <= operation;
      last_q <= last_letter;
      wt_q   <= weight;
      slot_q <= slot_addr;
    end
    if (res_fire) begin
      best_weight <= res_best;
      status      <= res_status;
    end
  end

  // link memory
  always_ff @(posedge clk) begin
    if (link_we) link_mem[link_wa] <= link_wd;
    link_rd <= link_mem[slot_addr];
  end

  // weight memory
  always_ff @(posedge clk) begin
    if (wt_we) weight_mem[wt_wa] <= wt_wd;
    weight_rd <= weight_mem[wt_ra];
  end

  `PTMW_ASSERT_IMP(a_pool_range, 1'b1, nodes_used != '0 && nodes_used <= USED_BITS'(NODE_COUNT))
  `PTMW_ASSERT_IMP(a_child_order, state == S_LINK && link_rd != '0, link_rd > cursor && USED_BITS'(link_rd) < nodes_used)
  `PTMW_ASSERT_IMP(a_quiet_clear, state == S_CLEAR, !done)
  `PTMW_ASSERT_NXT(a_weight_after_link, state_next == S_WEIGHT && state != S_WEIGHT, state == S_WEIGHT && $past(state) == S_LINK)

endmodule

>>> tb/sv/trie_lookup_checker.sv
// Checker: tracks the trie walk per transfer and compares lookup results.
`timescale 1ns / 1ps

module trie_lookup_checker
  import ptmw_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic                        busy,
  input  logic                        operation,
  input  logic [LETTER_BITS-1:0]      letter,
  input  logic [WEIGHT_BITS-1:0]      weight,
  input  logic                        first_letter,
  input  logic                        last_letter,
  input  logic                        done,
  input  logic signed [WEIGHT_BITS:0] best_weight,
  input  logic [1:0]                  status,
  output int                          error_count,
  output int                          outstanding
);

  typedef struct packed {
    logic signed [WEIGHT_BITS:0] best;
    logic [1:0]                  stat;
  } lookup_t;

  localparam logic signed [WEIGHT_BITS:0] NO_MATCH = '1;

  logic [NODE_BITS-1:0]   child_of [SLOT_COUNT];
  logic [WEIGHT_BITS-1:0] node_wt [NODE_COUNT];
  int unsigned            nodes_taken;
  logic [NODE_BITS-1:0]   cursor;
  logic                   walk_failed;
  lookup_t                expected_lookups [$];
  int                     mismatches;

  function automatic void clear_trie();
    foreach (child_of[i]) child_of[i] = '0;
    foreach (node_wt[i]) node_wt[i] = '0;
    nodes_taken = 1;
    cursor = '0;
    walk_failed = 1'b0;
  endfunction

  function automatic void walk_trie(logic is_query, logic [LETTER_BITS-1:0] ltr,
                                    logic [WEIGHT_BITS-1:0] wt, logic restart);
    int slot;
    logic [NODE_BITS-1:0] nxt;
    if (restart) begin
      cursor = '0;
      walk_failed = 1'b0;
    end
    if (walk_failed) return;
    if (int'(ltr) >= ALPHABET_SIZE) begin
      walk_failed = 1'b1;
      return;
    end
    slot = int'(cursor) * ALPHABET_SIZE + int'(ltr);
    nxt = child_of[slot];
    if (nxt != '0) begin
      cursor = nxt;
      if (!is_query && node_wt[nxt] < wt) node_wt[nxt] = wt;
      return;
    end
    if (is_query || nodes_taken >= NODE_COUNT) begin
      walk_failed = 1'b1;
      return;
    end
    nxt = nodes_taken[NODE_BITS-1:0];
    nodes_taken++;
    child_of[slot] = nxt;
    node_wt[nxt] = wt;
    cursor = nxt;
  endfunction

  function automatic lookup_t word_result(logic is_query);
    lookup_t res;
    if (is_query) begin
      res.best = walk_failed ? NO_MATCH : $signed({1'b0, node_wt[cursor]});
      res.stat = walk_failed ? STAT_NOT_FOUND : STAT_DONE;
    end else begin
      res.best = '0;
      res.stat = walk_failed ? STAT_TRUNCATED : STAT_DONE;
    end
    return res;
  endfunction

  always @(posedge clk) begin : watch
    lookup_t want;
    if (rst) begin
      clear_trie();
      expected_lookups.delete();
    end else begin
      if (done) begin
        if (expected_lookups.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: best_weight %0d status %0d", best_weight, status);
        end else begin
          want = expected_lookups.pop_front();
          if (best_weight !== want.best || status !== want.stat) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result mismatch: expected best_weight %0d status %0d, got %0d status %0d",
                       $signed(want.best), want.stat, best_weight, status);
          end
        end
      end
      if (start && !busy) begin
        walk_trie(operation, letter, weight, first_letter);
        if (last_letter) expected_lookups.push_back(word_result(operation));
      end
    end
    error_count <= mismatches;
    outstanding <= expected_lookups.size();
  end

endmodule

>>> tb/sv/tb_top.sv
// Testbench top: drives letter transfers into the trie block and gives the verdict.
`timescale 1ns / 1ps

module tb_top;
  import ptmw_pkg::*;

  localparam logic OP_INSERT    = 1'b0;
  localparam logic OP_QUERY     = 1'b1;
  localparam int   IDLE_LIMIT   = 400000;
  localparam int   DRAIN_CYCLES = 16;
  localparam int   RANDOM_ITEMS = 1500;
  localparam int   FILL_LETTERS = 40;

  logic                        clk;
  logic                        rst;
  logic                        start;
  logic                        busy;
  logic                        operation;
  logic [LETTER_BITS-1:0]      letter;
  logic [WEIGHT_BITS-1:0]      weight;
  logic                        first_letter;
  logic                        last_letter;
  logic                        done;
  logic signed [WEIGHT_BITS:0] best_weight;
  logic [1:0]                  status;
  int                          error_count;
  int                          outstanding;
  int                          items_sent;
  int                          calm_left;
  int                          quiet_cycles;

  prefix_trie_max_weight dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .operation    (operation),
    .letter       (letter),
    .weight       (weight),
    .first_letter (first_letter),
    .last_letter  (last_letter),
    .done         (done),
    .best_weight  (best_weight),
    .status       (status)
  );

  trie_lookup_checker lookup_check (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .operation    (operation),
    .letter       (letter),
    .weight       (weight),
    .first_letter (first_letter),
    .last_letter  (last_letter),
    .done         (done),
    .best_weight  (best_weight),
    .status       (status),
    .error_count  (error_count),
    .outstanding  (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // watchdog on quiet time, with a limit that covers the link-memory clearing pass after reset
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [WEIGHT_BITS-1:0] pick_weight();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      default: return WEIGHT_BITS'($urandom());
    endcase
  endfunction

  task automatic send_letter(logic op, logic [LETTER_BITS-1:0] ltr,
                             logic [WEIGHT_BITS-1:0] wt, logic first, logic last);
    int gap;
    if (calm_left > 0) begin
      calm_left--;
      gap = 0;
    end else if ($urandom_range(0, 15) == 0) begin
      calm_left = $urandom_range(8, 40);
      gap = 0;
    end else begin
      gap = $urandom_range(0, 12);
    end
    repeat (gap) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start        <= 1'b1;
    operation    <= op;
    letter       <= ltr;
    weight       <= wt;
    first_letter <= first;
    last_letter  <= last;
    do @(posedge clk); while (busy);
    items_sent++;
  endtask

  // mostly well-formed words over narrow alphabets so queries find shared prefixes
  task automatic random_words(int count);
    int stop_at;
    int kind;
    int len;
    int top;
    int bad;
    logic op;
    logic keep_first;
    logic [WEIGHT_BITS-1:0] wt;
    logic [LETTER_BITS-1:0] ltr;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      kind = $urandom_range(0, 99);
      len  = $urandom_range(1, 6);
      top  = ($urandom_range(0, 2) == 0) ? ALPHABET_SIZE - 1 : $urandom_range(1, 4);
      op   = (kind < 40) ? OP_INSERT : (kind < 80) ? OP_QUERY : logic'($urandom_range(0, 1));
      wt   = pick_weight();
      if (kind < 90) begin
        bad = (kind >= 80) ? $urandom_range(0, len) : len;
        keep_first = (kind < 80) || (bad != len) || ($urandom_range(0, 1) == 0);
        for (int i = 0; i < len; i++) begin
          ltr = (i == bad) ? LETTER_BITS'($urandom_range(ALPHABET_SIZE, 31))
                           : LETTER_BITS'($urandom_range(0, top));
          if (kind >= 80 && $urandom_range(0, 3) == 0) op = ~op;
          send_letter(op, ltr, wt, keep_first && i == 0, i == len - 1);
        end
      end else begin
        send_letter(op, LETTER_BITS'($urandom_range(0, 31)), WEIGHT_BITS'($urandom()),
                    logic'($urandom_range(0, 1)), logic'($urandom_range(0, 1)));
      end
    end
  endtask

  initial begin
    rst          <= 1'b1;
    start        <= 1'b0;
    operation    <= OP_INSERT;
    letter       <= '0;
    weight       <= '0;
    first_letter <= 1'b0;
    last_letter  <= 1'b0;
    items_sent   = 0;
    calm_left    = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // empty trie, min and max weights, max raise on an existing node
    send_letter(OP_QUERY,  0, '1, 1'b1, 1'b1);
    send_letter(OP_INSERT, 0, '0, 1'b1, 1'b1);
    send_letter(OP_QUERY,  0, '0, 1'b1, 1'b1);
    send_letter(OP_INSERT, 0, '1, 1'b1, 1'b0);
    send_letter(OP_INSERT, 1, '1, 1'b0, 1'b1);
    send_letter(OP_QUERY,  0, '0, 1'b1, 1'b1);
    send_letter(OP_INSERT, 25, 20'd5, 1'b1, 1'b1);
    send_letter(OP_QUERY,  25, '1, 1'b1, 1'b1);
    // letters past the alphabet
    send_letter(OP_INSERT, 31, 20'd7, 1'b1, 1'b1);
    send_letter(OP_QUERY,  26, '0, 1'b1, 1'b1);
    // mixed operations within one word
    send_letter(OP_INSERT, 2, 20'd9, 1'b1, 1'b0);
    send_letter(OP_QUERY,  3, '0, 1'b0, 1'b1);
    // walk continues without a restart, also past a last letter
    send_letter(OP_QUERY,  0, '0, 1'b1, 1'b0);
    send_letter(OP_QUERY,  1, '0, 1'b0, 1'b1);
    send_letter(OP_QUERY,  1, '0, 1'b0, 1'b1);
    // failed walk ignores letters until a restart
    send_letter(OP_INSERT, 30, 20'd3, 1'b1, 1'b0);
    send_letter(OP_INSERT, 0, 20'd3, 1'b0, 1'b1);
    send_letter(OP_QUERY,  0, '0, 1'b0, 1'b1);
    send_letter(OP_INSERT, 0, 20'd3, 1'b1, 1'b1);

    random_words(RANDOM_ITEMS);

    // one long insert word, then its prefix is queried and raised
    for (int i = 0; i < FILL_LETTERS; i++)
      send_letter(OP_INSERT, (i < 3) ? 5'd25 : 5'($urandom_range(0, ALPHABET_SIZE - 1)),
                  pick_weight(), i == 0, i == FILL_LETTERS - 1);
    for (int i = 0; i < 3; i++) send_letter(OP_QUERY, 25, '0, i == 0, i == 2);
    for (int i = 0; i < 3; i++) send_letter(OP_INSERT, 25, '1, i == 0, i == 2);
    for (int i = 0; i < 2; i++) send_letter(OP_QUERY, 25, '0, i == 0, i == 1);
    for (int i = 0; i < 8; i++)
      send_letter(OP_INSERT, LETTER_BITS'($urandom_range(0, ALPHABET_SIZE - 1)),
                  pick_weight(), i == 0, i == 7);
    random_words(80);
    start <= 1'b0;

    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && outstanding == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

>>> files.f
+incdir+design
design/ptmw_pkg.sv
design/prefix_trie_max_weight.sv
tb/sv/trie_lookup_checker.sv
tb/sv/tb_top.sv
